// ===== rtl/lphm_pkg.sv =====
// ----------------------------------------------------------------------------
// lphm_pkg
// Shared types and constants of the linear probing hash map engine.
// ----------------------------------------------------------------------------
package lphm_pkg;

    localparam int KEY_W   = 64;
    localparam int VALUE_W = 64;
    localparam int COUNT_W = 7;

    localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic               live;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_slot;

    typedef enum logic [2:0] {
        M_CLEAR,
        M_IDLE,
        M_HASH,
        M_PROBE,
        M_RESP
    } t_map_state;

    typedef enum logic [3:0] {
        H_IDLE,
        H_MULA0,
        H_MULA1,
        H_MULA2,
        H_XOR27,
        H_MULB0,
        H_MULB1,
        H_MULB2,
        H_XOR31,
        H_FOLD0,
        H_FOLD1,
        H_RECIP,
        H_REM,
        H_FIX,
        H_DONE
    } t_hash_state;

endpackage

// ===== rtl/lphm_ram.sv =====
// ----------------------------------------------------------------------------
// lphm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lphm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lphm_hash.sv =====
// ----------------------------------------------------------------------------
// lphm_hash
// Multi-cycle key mixer: 64-bit finalizer on one shared 32x32 multiplier,
// then reduction of the hash to a home slot index by folding and a
// reciprocal multiply when TABLE_SLOTS is not a power of two.
// ----------------------------------------------------------------------------
module lphm_hash #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [lphm_pkg::KEY_W-1:0]     i_key,
    output logic                           o_done,
    output logic [$clog2(TABLE_SLOTS)-1:0] o_home
);

    import lphm_pkg::*;

    localparam int  AW      = $clog2(TABLE_SLOTS);
    localparam bit  IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

    localparam logic [15:0] FOLD_R16 = 16'((64'd1 << 16) % 64'(TABLE_SLOTS));
    localparam logic [15:0] FOLD_R32 = 16'((64'd1 << 32) % 64'(TABLE_SLOTS));
    localparam logic [15:0] FOLD_R48 = 16'((64'd1 << 48) % 64'(TABLE_SLOTS));
    localparam logic [30:0] RECIP    = 31'((64'd1 << 33) / 64'(TABLE_SLOTS));

    t_hash_state r_state;
    t_hash_state n_state;

    logic [63:0]   r_x;
    logic [63:0]   n_x;
    logic [63:0]   r_acc;
    logic [63:0]   n_acc;
    logic [AW-1:0] r_rem;
    logic [AW-1:0] n_rem;

    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [63:0]   prod;
    logic [63:0]   recip_prod;

    assign prod       = 64'(mul_a) * 64'(mul_b);
    assign recip_prod = 64'(r_acc[32:0]) * 64'(RECIP);

    always_comb begin
        n_state = r_state;
        case (r_state)
            H_IDLE:  if (i_start) n_state = H_MULA0;
            H_MULA0: n_state = H_MULA1;
            H_MULA1: n_state = H_MULA2;
            H_MULA2: n_state = H_XOR27;
            H_XOR27: n_state = H_MULB0;
            H_MULB0: n_state = H_MULB1;
            H_MULB1: n_state = H_MULB2;
            H_MULB2: n_state = H_XOR31;
            H_XOR31: n_state = IS_POW2 ? H_DONE : H_FOLD0;
            H_FOLD0: n_state = H_FOLD1;
            H_FOLD1: n_state = H_RECIP;
            H_RECIP: n_state = H_REM;
            H_REM:   n_state = H_FIX;
            H_FIX:   n_state = H_DONE;
            H_DONE:  n_state = H_IDLE;
            default: n_state = H_IDLE;
        endcase
    end

    always_comb begin
        mul_a = r_x[31:0];
        mul_b = MIX_MUL_A[31:0];
        n_x   = r_x;
        n_acc = r_acc;
        n_rem = r_rem;
        case (r_state)
            H_IDLE: begin
                if (i_start) begin
                    n_x = i_key ^ (i_key >> 30);
                end
            end
            H_MULA0: begin
                n_acc = prod;
            end
            H_MULA1: begin
                mul_b = MIX_MUL_A[63:32];
                n_acc = {r_acc[63:32] + prod[31:0], r_acc[31:0]};
            end
            H_MULA2: begin
                mul_a = r_x[63:32];
                n_acc = {r_acc[63:32] + prod[31:0], r_acc[31:0]};
            end
            H_XOR27: begin
                n_x = r_acc ^ (r_acc >> 27);
            end
            H_MULB0: begin
                mul_b = MIX_MUL_B[31:0];
                n_acc = prod;
            end
            H_MULB1: begin
                mul_b = MIX_MUL_B[63:32];
                n_acc = {r_acc[63:32] + prod[31:0], r_acc[31:0]};
            end
            H_MULB2: begin
                mul_a = r_x[63:32];
                mul_b = MIX_MUL_B[31:0];
                n_acc = {r_acc[63:32] + prod[31:0], r_acc[31:0]};
            end
            H_XOR31: begin
                n_x = (r_acc ^ (r_acc >> 31)) | 64'd1;
            end
            H_FOLD0: begin
                n_acc = 64'(32'(r_x[63:48]) * 32'(FOLD_R48))
                      + 64'(32'(r_x[47:32]) * 32'(FOLD_R32))
                      + 64'(32'(r_x[31:16]) * 32'(FOLD_R16))
                      + 64'(r_x[15:0]);
            end
            H_FOLD1: begin
                n_acc = 64'(32'(r_acc[33:32]) * 32'(FOLD_R32))
                      + 64'(32'(r_acc[31:16]) * 32'(FOLD_R16))
                      + 64'(r_acc[15:0]);
            end
            H_RECIP: begin
                n_x = 64'(recip_prod[63:33]);
            end
            H_REM: begin
                n_acc = r_acc - (64'(r_x[30:0]) * 64'(TABLE_SLOTS));
            end
            H_FIX: begin
                if (r_acc[16:0] >= 17'(TABLE_SLOTS)) begin
                    n_rem = AW'(r_acc[16:0] - 17'(TABLE_SLOTS));
                end else begin
                    n_rem = AW'(r_acc[16:0]);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_x   <= n_x;
        r_acc <= n_acc;
        r_rem <= n_rem;
    end

    assign o_done = (r_state == H_DONE);
    assign o_home = IS_POW2 ? r_x[AW-1:0] : r_rem;

endmodule

// ===== rtl/linear_probe_hash_map_i64.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_map_i64
// Open addressing hash map with linear probing, 64-bit keys and values.
//
//   channel  | dir | tdata                          | tuser
//   s_axis   | in  | key[63:0], value[127:64]       | req_type[0]
//   m_axis   | out | read_value[63:0], live[70:64]  | found[0], status[2:1]
//
// An item is accepted in M_IDLE, passes through the key mixer (with the home
// slot reduction steps added when TABLE_SLOTS is not a power of two), visits
// the slots of its probe path one by one through the slot RAM read port, and
// then posts its result; the next item is accepted only after that. After
// reset every slot RAM entry is cleared with s_axis_tready low.
// A stalled result waits in the output register while the next item is
// accepted and processed up to its own result.
// ----------------------------------------------------------------------------
module linear_probe_hash_map_i64 #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // key, value
    input  logic [0:0]   s_axis_tuser,   // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,   // read_value, live_count, zero pad
    output logic [2:0]   m_axis_tuser    // found, status
);

    import lphm_pkg::*;

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS / 2 + 2);
    localparam int SW = $bits(t_slot);

    t_map_state r_state;
    t_map_state n_state;

    logic [AW-1:0]      r_clr;
    logic [AW-1:0]      r_pos;
    logic [AW-1:0]      n_pos;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_req;
    logic [KEY_W-1:0]   r_key;
    logic [VALUE_W-1:0] r_value;

    logic               r_res_found;
    logic               n_res_found;
    logic [VALUE_W-1:0] r_res_rval;
    logic [VALUE_W-1:0] n_res_rval;
    logic [1:0]         r_res_status;
    logic [1:0]         n_res_status;

    logic               r_out_valid;
    logic               r_out_found;
    logic [VALUE_W-1:0] r_out_rval;
    logic [1:0]         r_out_status;
    logic [COUNT_W-1:0] r_out_count;

    logic               accept;
    logic               out_free;
    logic               hash_done;
    logic [AW-1:0]      hash_home;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    t_slot              ram_wdata;
    t_slot              rd;
    logic               hit;
    logic               full;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign hit      = rd.live && (rd.key == r_key);
    assign full     = {r_count, 1'b0} >= (CW + 1)'(TABLE_SLOTS);

    lphm_hash #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_key   (s_axis_tdata[63:0]),
        .o_done  (hash_done),
        .o_home  (hash_home)
    );

    lphm_ram #(
        .WIDTH (SW),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_pos),
        .o_rdata (rd)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            M_CLEAR: if (r_clr == AW'(TABLE_SLOTS - 1)) n_state = M_IDLE;
            M_IDLE:  if (s_axis_tvalid) n_state = M_HASH;
            M_HASH:  if (hash_done) n_state = M_PROBE;
            M_PROBE: if (!rd.live || hit) n_state = M_RESP;
            M_RESP:  if (out_free) n_state = M_IDLE;
            default: n_state = M_IDLE;
        endcase
    end

    always_comb begin
        ram_we       = 1'b0;
        ram_waddr    = r_pos;
        ram_wdata    = '{live: 1'b1, key: r_key, value: r_value};
        n_pos        = r_pos;
        n_count      = r_count;
        n_res_found  = r_res_found;
        n_res_rval   = r_res_rval;
        n_res_status = r_res_status;
        case (r_state)
            M_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            M_HASH: begin
                if (hash_done) begin
                    n_pos = hash_home;
                end
            end
            M_PROBE: begin
                n_res_found  = hit;
                n_res_rval   = '0;
                n_res_status = ST_OK;
                if (hit) begin
                    if (r_req == REQ_LOOKUP) begin
                        n_res_rval = rd.value;
                    end else begin
                        ram_we = 1'b1;
                    end
                end else if (!rd.live) begin
                    if (r_req == REQ_LOOKUP) begin
                        n_res_status = ST_NOT_FOUND;
                    end else if (full) begin
                        n_res_status = ST_FULL;
                    end else begin
                        ram_we  = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end else if (r_pos == AW'(TABLE_SLOTS - 1)) begin
                    n_pos = '0;
                end else begin
                    n_pos = r_pos + AW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= M_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == M_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (r_state == M_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_pos        <= n_pos;
        r_res_found  <= n_res_found;
        r_res_rval   <= n_res_rval;
        r_res_status <= n_res_status;
        if (accept) begin
            r_req   <= s_axis_tuser[0];
            r_key   <= s_axis_tdata[63:0];
            r_value <= s_axis_tdata[127:64];
        end
        if (r_state == M_RESP && out_free) begin
            r_out_found  <= r_res_found;
            r_out_rval   <= r_res_rval;
            r_out_status <= r_res_status;
            r_out_count  <= COUNT_W'(32'(r_count));
        end
    end

    assign s_axis_tready = (r_state == M_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_count, r_out_rval};
    assign m_axis_tuser  = {r_out_status, r_out_found};

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the linear probing hash map engine. Directed
// tests cover lookups in an empty table, the key extremes, updates of present
// keys and a probe path that wraps past the last slot. Random traffic then
// fills the table to half full and mixes inserts, updates, lookup hits,
// lookup misses and near-miss keys. Each result is checked against a local
// copy of the table, under three sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_top;

    import lphm_pkg::*;

    localparam int TABLE_SLOTS    = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] read_value;
        logic [1:0]         status;
        logic [COUNT_W-1:0] live_count;
    } t_map_result;

    logic         i_clk          = 1'b0;
    logic         i_rst_n        = 1'b0;
    logic         s_axis_tvalid  = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata   = '0;   // key, value
    logic [0:0]   s_axis_tuser   = '0;   // req_type
    logic         m_axis_tvalid;
    logic         m_axis_tready  = 1'b0;
    logic [71:0]  m_axis_tdata;          // read_value, live_count, zero pad
    logic [2:0]   m_axis_tuser;          // found, status

    logic [63:0]  map_hash  [TABLE_SLOTS];
    logic [63:0]  map_key   [TABLE_SLOTS];
    logic [63:0]  map_value [TABLE_SLOTS];
    int           map_count;

    t_map_result  pending_results [$];
    logic [63:0]  key_pool [$];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int error_count   = 0;
    int stall_cycles  = 0;

    linear_probe_hash_map_i64 #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] mix_hash(input logic [63:0] k);
        logic [63:0] x;
        x = k;
        x = x ^ (x >> 30);
        x = x * MIX_MUL_A;
        x = x ^ (x >> 27);
        x = x * MIX_MUL_B;
        x = x ^ (x >> 31);
        return x | 64'd1;
    endfunction

    function automatic int home_slot(input logic [63:0] k);
        return int'(mix_hash(k) % 64'(TABLE_SLOTS));
    endfunction

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] key_with_home(input int slot);
        logic [63:0] k;
        k = random_word();
        while (home_slot(k) != slot)
            k = random_word();
        return k;
    endfunction

    // Walk the probe path, then apply the request to the local table.
    function automatic t_map_result apply_request(input logic req, input logic [63:0] key,
                                                  input logic [63:0] value);
        t_map_result res;
        logic [63:0] h;
        int          pos;
        bit          hit;
        bit          empty_seen;
        h          = mix_hash(key);
        pos        = home_slot(key);
        hit        = 1'b0;
        empty_seen = 1'b0;
        for (int n = 0; n < TABLE_SLOTS; n++) begin
            if (map_hash[pos] == 64'd0) begin
                empty_seen = 1'b1;
                break;
            end
            if (map_hash[pos] == h && map_key[pos] == key) begin
                hit = 1'b1;
                break;
            end
            pos = (pos + 1) % TABLE_SLOTS;
        end
        res.found      = hit;
        res.read_value = '0;
        res.status     = ST_OK;
        if (req == REQ_LOOKUP) begin
            if (hit)
                res.read_value = map_value[pos];
            else
                res.status = ST_NOT_FOUND;
        end else if (hit) begin
            map_value[pos] = value;
        end else if (map_count * 2 >= TABLE_SLOTS || !empty_seen) begin
            res.status = ST_FULL;
        end else begin
            map_hash[pos]  = h;
            map_key[pos]   = key;
            map_value[pos] = value;
            map_count++;
        end
        res.live_count = COUNT_W'(map_count);
        return res;
    endfunction

    task automatic send_item(input logic req, input logic [63:0] key, input logic [63:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, key};
        s_axis_tuser  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(apply_request(req, key, value));
    endtask

    task automatic test_empty_lookup();
        send_item(REQ_LOOKUP, 64'd0, random_word());
        send_item(REQ_LOOKUP, 64'h8000_0000_0000_0000, 64'd0);
    endtask

    task automatic test_key_extremes();
        logic [63:0] keys [4];
        logic [63:0] vals [4];
        keys = '{64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 64'd0, '1};
        vals = '{'1, 64'd0, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa};
        foreach (keys[i])
            send_item(REQ_INSERT, keys[i], vals[i]);
        foreach (keys[i])
            send_item(REQ_LOOKUP, keys[i], random_word());
    endtask

    task automatic test_update();
        send_item(REQ_INSERT, 64'h7fff_ffff_ffff_ffff, 64'h0123_4567_89ab_cdef);
        send_item(REQ_LOOKUP, 64'h7fff_ffff_ffff_ffff, 64'd0);
    endtask

    task automatic test_probe_wrap();
        logic [63:0] tail_keys [3];
        foreach (tail_keys[i]) begin
            tail_keys[i] = key_with_home(TABLE_SLOTS - 1);
            send_item(REQ_INSERT, tail_keys[i], random_word());
        end
        send_item(REQ_LOOKUP, tail_keys[2], 64'd0);
        send_item(REQ_LOOKUP, key_with_home(TABLE_SLOTS - 1), 64'd0);
    endtask

    task automatic test_random_traffic(input int src_idle, input int sink_idle, input int count);
        int          pick;
        logic [63:0] key;
        src_idle_pct  = src_idle;
        sink_idle_pct = sink_idle;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 20 || key_pool.size() == 0) begin
                key = random_word();
                key_pool.push_back(key);
                send_item(REQ_INSERT, key, random_word());
            end else if (pick < 45) begin
                key = key_pool[$urandom_range(key_pool.size() - 1)];
                send_item(REQ_INSERT, key, random_word());
            end else if (pick < 75) begin
                key = key_pool[$urandom_range(key_pool.size() - 1)];
                send_item(REQ_LOOKUP, key, random_word());
            end else if (pick < 88) begin
                send_item(REQ_LOOKUP, random_word(), random_word());
            end else begin
                key = key_pool[$urandom_range(key_pool.size() - 1)];
                key[$urandom_range(63)] ^= 1'b1;
                send_item(logic'($urandom_range(1)), key, random_word());
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_map_result expected;
        t_map_result actual;
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            actual.found      = m_axis_tuser[0];
            actual.status     = m_axis_tuser[2:1];
            actual.read_value = m_axis_tdata[63:0];
            actual.live_count = m_axis_tdata[70:64];
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected item: found=%0d value=%h status=%0d live=%0d",
                             actual.found, actual.read_value, actual.status,
                             actual.live_count);
            end else begin
                expected = pending_results.pop_front();
                if (actual.found != expected.found
                        || actual.read_value != expected.read_value
                        || actual.status != expected.status
                        || actual.live_count != expected.live_count) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display({"mismatch: expected found=%0d value=%h status=%0d live=%0d,",
                                  " got found=%0d value=%h status=%0d live=%0d"},
                                 expected.found, expected.read_value, expected.status,
                                 expected.live_count, actual.found, actual.read_value,
                                 actual.status, actual.live_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        foreach (map_hash[i]) begin
            map_hash[i]  = '0;
            map_key[i]   = '0;
            map_value[i] = '0;
        end
        map_count     = 0;
        src_idle_pct  = 31;
        sink_idle_pct = 69;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_lookup();
        test_key_extremes();
        test_update();
        test_probe_wrap();
        test_random_traffic(31, 69, 360);
        test_random_traffic(69, 31, 360);
        test_random_traffic(0, 0, 360);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
